### sv/i2csr_pkg.sv
// Package for the I2C slave byte RAM: widths, bus phase codes, register map and RAM request type.
`timescale 1ns / 1ps
`default_nettype none

package i2csr_pkg;

  localparam int PTR_W  = 8;   // register pointer, wraps at 256
  localparam int DATA_W = 8;   // one I2C byte

  localparam int RAM_DEPTH_DEF = 256;

  localparam logic [6:0] SLAVE_ADDR_RST = 7'h50;

  // Configuration register index, taken from paddr[2]
  localparam logic REG_SLAVE_ADDR = 1'b0;

  // Bus phase codes
  localparam logic [3:0] PH_IDLE          = 4'd0;
  localparam logic [3:0] PH_ADDR          = 4'd1;
  localparam logic [3:0] PH_ACK_READ      = 4'd2;
  localparam logic [3:0] PH_ACK_READ_ADDR = 4'd3;
  localparam logic [3:0] PH_ACK_WRITE     = 4'd4;
  localparam logic [3:0] PH_READ          = 4'd6;
  localparam logic [3:0] PH_WRITE         = 4'd7;
  localparam logic [3:0] PH_WAIT          = 4'd8;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  // Request from the protocol logic to the byte RAM, one per clock
  typedef struct packed {
    logic              wr_en;
    logic [PTR_W-1:0]  wr_ptr;
    logic [DATA_W-1:0] wr_data;
    logic [PTR_W-1:0]  rd_ptr;
  } ram_req_t;

endpackage

`default_nettype wire

### sv/i2c_slave_byte_ram_core.sv
// Top level: I2C slave protocol engine on sampled pins, in front of a byte RAM.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+-------------------------------------
//  in_     | in  | in_tvalid / in_tready  | in_tdata[0] scl, [1] sda
//  out_    | out | out_tvalid / out_tready| out_tdata[0] sda_out
//  cfg_    | in  | APB r/w, pready = 1    | reg 0 @ 0x0: slave_address[6:0]
//
// One pin sample per clock unless the output stalls, one sda_out item per sample,
// valid in the cycle after the sample is taken. The whole bus step is done in one
// pass; the RAM is read ahead at the pointer the step leaves, so reads add no wait.
// An output register parts the two sides: a new sample is taken while the last
// result waits, unless that result is stalled and out_tready is low.
// Synchronous reset; RAM entries read as zero until written (per-entry valid
// bits), so no clearing pass is needed and the block accepts items at once.
`timescale 1ns / 1ps
`default_nettype none

module i2c_slave_byte_ram_core
  import i2csr_pkg::*;
#(
  parameter int RAM_DEPTH = RAM_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // sample stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,      // [0] scl, [1] sda
  // driven SDA level stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,     // [0] sda_out
  // configuration
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  // ---------------- configuration ----------------
  logic [6:0] slave_addr_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_SLAVE_ADDR) ? {25'b0, slave_addr_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_addr_r <= SLAVE_ADDR_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == REG_SLAVE_ADDR) begin
      slave_addr_r <= cfg_pwdata[6:0];
    end
  end

  // ---------------- bus state ----------------
  logic              prev_scl_r,  prev_scl_nxt;
  logic              prev_sda_r,  prev_sda_nxt;
  logic [3:0]        phase_r,     phase_nxt;
  logic [3:0]        bit_cnt_r,   bit_cnt_nxt;
  logic [DATA_W-1:0] shift_in_r,  shift_in_nxt;
  logic [DATA_W-1:0] shift_out_r, shift_out_nxt;
  logic              selected_r,  selected_nxt;
  logic [PTR_W-1:0]  ptr_r,       ptr_nxt;
  logic              ptr_phase_r, ptr_phase_nxt;   // 0: next write byte is the pointer
  logic              sda_drive_r, sda_drive_nxt;

  logic              out_valid_r;
  logic              out_sda_r;

  logic              acc;
  logic              scl, sda;
  logic              fall, rise;
  logic              start_cond, stop_cond;
  logic [DATA_W-1:0] ram_q;
  ram_req_t          ram_req;

  assign in_tready = !out_valid_r || out_tready;
  assign acc       = in_tvalid && in_tready;
  assign scl       = in_tdata[0];
  assign sda       = in_tdata[1];
  assign fall      = prev_scl_r && !scl;
  assign rise      = !prev_scl_r && scl;
  assign start_cond = scl && prev_sda_r && !sda;
  assign stop_cond  = scl && !prev_sda_r && sda;

  always_comb begin
    prev_scl_nxt  = scl;
    prev_sda_nxt  = sda;
    phase_nxt     = phase_r;
    bit_cnt_nxt   = bit_cnt_r;
    shift_in_nxt  = shift_in_r;
    shift_out_nxt = shift_out_r;
    selected_nxt  = selected_r;
    ptr_nxt       = ptr_r;
    ptr_phase_nxt = ptr_phase_r;
    sda_drive_nxt = sda_drive_r;
    ram_req.wr_en   = 1'b0;
    ram_req.wr_ptr  = ptr_r;
    ram_req.wr_data = '0;

    if (start_cond || stop_cond) begin
      // start or stop clears the bus side; pointer and RAM survive
      if (stop_cond && selected_r) ptr_phase_nxt = 1'b0;
      phase_nxt     = start_cond ? PH_ADDR : PH_IDLE;
      bit_cnt_nxt   = '0;
      shift_in_nxt  = '0;
      shift_out_nxt = '0;
      selected_nxt  = 1'b0;
      sda_drive_nxt = 1'b1;
    end else begin
      case (phase_r)
        PH_ADDR: begin
          if (fall) begin
            sda_drive_nxt = 1'b1;
          end else if (rise) begin
            bit_cnt_nxt  = bit_cnt_r + 4'd1;
            shift_in_nxt = {shift_in_r[DATA_W-2:0], sda};
            if (bit_cnt_nxt == BITS_PER_BYTE) begin
              if (shift_in_nxt[DATA_W-1:1] == slave_addr_r) begin
                phase_nxt     = shift_in_nxt[0] ? PH_ACK_READ_ADDR : PH_ACK_WRITE;
                ptr_phase_nxt = 1'b0;
                selected_nxt  = 1'b1;
                sda_drive_nxt = 1'b1;
              end else begin
                // not our address: drop off the bus
                phase_nxt     = PH_IDLE;
                bit_cnt_nxt   = '0;
                shift_in_nxt  = '0;
                shift_out_nxt = '0;
                selected_nxt  = 1'b0;
                sda_drive_nxt = 1'b1;
              end
            end
          end
        end
        PH_ACK_READ_ADDR: begin
          if (fall) begin
            sda_drive_nxt = 1'b0;
          end else if (rise) begin
            phase_nxt   = PH_READ;
            bit_cnt_nxt = BITS_PER_BYTE;
          end
        end
        PH_ACK_READ: begin
          if (fall) begin
            sda_drive_nxt = 1'b1;
          end else if (rise) begin
            if (sda) begin
              phase_nxt = PH_WAIT;          // master NACK
            end else begin
              phase_nxt   = PH_READ;
              bit_cnt_nxt = BITS_PER_BYTE;
            end
          end
        end
        PH_ACK_WRITE: begin
          if (fall) begin
            sda_drive_nxt = 1'b0;
          end else if (rise) begin
            phase_nxt    = PH_WRITE;
            bit_cnt_nxt  = '0;
            shift_in_nxt = '0;
          end
        end
        PH_READ: begin
          if (fall) begin
            if (bit_cnt_r == BITS_PER_BYTE) begin
              shift_out_nxt = ram_q;
              ptr_nxt       = ptr_r + 1'b1;
            end
            if (bit_cnt_r != 4'd0) begin
              bit_cnt_nxt   = bit_cnt_r - 4'd1;
              sda_drive_nxt = shift_out_nxt[bit_cnt_nxt[2:0]];
            end
          end else if (rise) begin
            if (bit_cnt_r == 4'd0) phase_nxt = PH_ACK_READ;
          end
        end
        PH_WRITE: begin
          if (fall) begin
            sda_drive_nxt = 1'b1;
          end else if (rise) begin
            bit_cnt_nxt  = bit_cnt_r + 4'd1;
            shift_in_nxt = {shift_in_r[DATA_W-2:0], sda};
            if (bit_cnt_nxt == BITS_PER_BYTE) begin
              if (!ptr_phase_r) begin
                ptr_nxt       = shift_in_nxt;
                ptr_phase_nxt = 1'b1;
              end else begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_data = shift_in_nxt;
                ptr_nxt         = ptr_r + 1'b1;
              end
              phase_nxt = PH_ACK_WRITE;
            end
          end
        end
        PH_WAIT: begin
          // hold until start or stop
        end
        default: begin
          // idle and unused codes
          sda_drive_nxt = 1'b1;
        end
      endcase
    end

    // writes only land on an accepted sample
    ram_req.wr_en  = ram_req.wr_en && acc;
    // fetch ahead at the pointer the next sample will see
    ram_req.rd_ptr = acc ? ptr_nxt : ptr_r;
  end

  i2csr_ram #(
    .RAM_DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (ram_req),
    .rd_data (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_scl_r  <= 1'b1;
      prev_sda_r  <= 1'b0;
      phase_r     <= PH_IDLE;
      bit_cnt_r   <= '0;
      shift_in_r  <= '0;
      shift_out_r <= '0;
      selected_r  <= 1'b0;
      ptr_r       <= '0;
      ptr_phase_r <= 1'b0;
      sda_drive_r <= 1'b1;
    end else if (acc) begin
      prev_scl_r  <= prev_scl_nxt;
      prev_sda_r  <= prev_sda_nxt;
      phase_r     <= phase_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      shift_in_r  <= shift_in_nxt;
      shift_out_r <= shift_out_nxt;
      selected_r  <= selected_nxt;
      ptr_r       <= ptr_nxt;
      ptr_phase_r <= ptr_phase_nxt;
      sda_drive_r <= sda_drive_nxt;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (acc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) out_sda_r <= sda_drive_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_sda_r};

  // ---------------- assertions ----------------
  a_acc_gives_item: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> out_tvalid)
    else $error("accepted sample produced no output item");

  a_low_only_when_talking: assert property (@(posedge clk) disable iff (!rst_n)
    !sda_drive_r |-> (phase_r == PH_READ || phase_r == PH_ACK_READ ||
                      phase_r == PH_ACK_READ_ADDR || phase_r == PH_ACK_WRITE ||
                      phase_r == PH_WRITE))
    else $error("SDA pulled low outside a data or acknowledge phase");

  a_unselected_phase: assert property (@(posedge clk) disable iff (!rst_n)
    !selected_r |-> (phase_r == PH_IDLE || phase_r == PH_ADDR))
    else $error("transfer phase reached without address match");

  a_bit_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_cnt_r <= BITS_PER_BYTE)
    else $error("bit counter past one byte");

endmodule

`default_nettype wire

### sv/i2csr_ram.sv
// Byte RAM with per-entry valid bits, write forwarding and a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module i2csr_ram
  import i2csr_pkg::*;
#(
  parameter int RAM_DEPTH = RAM_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ram_req_t          req,
  output logic [DATA_W-1:0]      rd_data
);

  localparam int IDX_W = $clog2(RAM_DEPTH);
  localparam logic [PTR_W+3:0] DEPTH_EXT = (PTR_W+4)'(RAM_DEPTH);

  // pointer modulo depth: quotient is below 16 for a depth of 16 or more, so four compare/subtract steps
  function automatic logic [PTR_W-1:0] ptr_mod(input logic [PTR_W-1:0] p);
    logic [PTR_W+3:0] r;
    r = {4'b0, p};
    for (int k = 3; k >= 0; k--) begin
      if (r >= (DEPTH_EXT << k)) r = r - (DEPTH_EXT << k);
    end
    return r[PTR_W-1:0];
  endfunction

  logic [DATA_W-1:0] mem [RAM_DEPTH];
  logic [RAM_DEPTH-1:0] valid_r;
  logic [IDX_W-1:0] wr_idx;
  logic [IDX_W-1:0] rd_idx;
  logic [DATA_W-1:0] rd_raw_r;
  logic [DATA_W-1:0] fwd_data_r;
  logic rd_ok_r;
  logic fwd_r;

  logic [PTR_W-1:0] wr_mod;
  logic [PTR_W-1:0] rd_mod;

  assign wr_mod = ptr_mod(req.wr_ptr);
  assign rd_mod = ptr_mod(req.rd_ptr);
  assign wr_idx = wr_mod[IDX_W-1:0];
  assign rd_idx = rd_mod[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (req.wr_en) mem[wr_idx] <= req.wr_data;
    rd_raw_r   <= mem[rd_idx];
    fwd_data_r <= req.wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      rd_ok_r <= 1'b0;
      fwd_r   <= 1'b0;
    end else begin
      if (req.wr_en) valid_r[wr_idx] <= 1'b1;
      rd_ok_r <= valid_r[rd_idx];
      fwd_r   <= req.wr_en && (wr_idx == rd_idx);
    end
  end

  // never-written entries read as the cleared value
  assign rd_data = fwd_r ? fwd_data_r : (rd_ok_r ? rd_raw_r : '0);

endmodule

`default_nettype wire

### dv/i2c_slave_byte_ram_core_test.sv
// Self-checking test of the I2C slave byte RAM core: pin-level bus traffic against a predictor.
`timescale 1ns / 1ps

module i2c_slave_byte_ram_core_test;
  import i2csr_pkg::*;

  // Cycles without any handshake before the run is declared hung. The worst correct
  // stretch is a receiver stall pattern plus a sender gap.
  localparam int WATCHDOG_LIMIT = 4000;
  // Random pin samples per address setting. The directed traffic adds about 560
  // samples, and each setting overshoots its target by part of one transaction,
  // so the whole run comes to about 1250 samples.
  localparam int SAMPLES_PER_SETTING = 100;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;    // [0] scl, [1] sda, [7:2] zero
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;           // [0] sda_out
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = 3'd0;
  logic [31:0] cfg_pwdata = 32'd0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  i2c_slave_byte_ram_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // Shadow of the slave: bus phase, shifters, pointer and RAM. Each accepted pin
  // sample yields the SDA level the slave should drive afterwards; those levels
  // wait in sda_due_q until the matching out_ item shows up.
  class sda_line_board;
    bit [6:0]   own_addr;
    bit         last_scl;
    bit         last_sda;
    logic [3:0] phase;
    bit [3:0]   nbits;
    bit [7:0]   rx_byte;
    bit [7:0]   tx_byte;
    bit         selected;
    bit [7:0]   ptr;
    bit         ptr_loaded;   // 0: next written byte sets the pointer
    bit         drive;
    bit [7:0]   ram [RAM_DEPTH_DEF];
    bit         sda_due_q [$];
    int         errors;

    function new();
      own_addr   = SLAVE_ADDR_RST;
      last_scl   = 1'b1;
      last_sda   = 1'b0;
      ptr        = '0;
      ptr_loaded = 1'b0;
      errors     = 0;
      foreach (ram[i]) ram[i] = '0;
      clear_bus();
    endfunction

    function void set_address(bit [6:0] a);
      own_addr = a;
    endfunction

    // start/stop/foreign address: pointer and RAM survive
    function void clear_bus();
      phase    = PH_IDLE;
      nbits    = '0;
      rx_byte  = '0;
      tx_byte  = '0;
      selected = 1'b0;
      drive    = 1'b1;
    endfunction

    function void take_sample(bit scl, bit sda);
      bit fall;
      bit rise;
      fall = last_scl && !scl;
      rise = !last_scl && scl;
      if (scl && last_sda && !sda) begin
        clear_bus();
        phase = PH_ADDR;
      end else if (scl && !last_sda && sda) begin
        if (selected) ptr_loaded = 1'b0;
        clear_bus();
      end else begin
        case (phase)
          PH_ADDR: begin
            if (fall) begin
              drive = 1'b1;
            end else if (rise) begin
              nbits   = nbits + 1'b1;
              rx_byte = {rx_byte[6:0], sda};
              if (nbits == BITS_PER_BYTE) begin
                if (rx_byte[7:1] == own_addr) begin
                  phase      = rx_byte[0] ? PH_ACK_READ_ADDR : PH_ACK_WRITE;
                  ptr_loaded = 1'b0;
                  selected   = 1'b1;
                  drive      = 1'b1;
                end else begin
                  clear_bus();
                end
              end
            end
          end
          PH_ACK_READ_ADDR: begin
            if (fall) begin
              drive = 1'b0;
            end else if (rise) begin
              phase = PH_READ;
              nbits = BITS_PER_BYTE;
            end
          end
          PH_ACK_READ: begin
            if (fall) begin
              drive = 1'b1;
            end else if (rise) begin
              if (sda) begin
                phase = PH_WAIT;
              end else begin
                phase = PH_READ;
                nbits = BITS_PER_BYTE;
              end
            end
          end
          PH_ACK_WRITE: begin
            if (fall) begin
              drive = 1'b0;
            end else if (rise) begin
              phase   = PH_WRITE;
              nbits   = '0;
              rx_byte = '0;
            end
          end
          PH_READ: begin
            if (fall) begin
              if (nbits == BITS_PER_BYTE) begin
                tx_byte = ram[ptr % RAM_DEPTH_DEF];
                ptr     = ptr + 1'b1;
              end
              if (nbits != 0) begin
                nbits = nbits - 1'b1;
                drive = tx_byte[nbits[2:0]];
              end
            end else if (rise) begin
              if (nbits == 0) phase = PH_ACK_READ;
            end
          end
          PH_WRITE: begin
            if (fall) begin
              drive = 1'b1;
            end else if (rise) begin
              nbits   = nbits + 1'b1;
              rx_byte = {rx_byte[6:0], sda};
              if (nbits == BITS_PER_BYTE) begin
                if (!ptr_loaded) begin
                  ptr        = rx_byte;
                  ptr_loaded = 1'b1;
                end else begin
                  ram[ptr % RAM_DEPTH_DEF] = rx_byte;
                  ptr = ptr + 1'b1;
                end
                phase = PH_ACK_WRITE;
              end
            end
          end
          PH_WAIT: begin
          end
          default: begin
            drive = 1'b1;
          end
        endcase
      end
      last_scl = scl;
      last_sda = sda;
      sda_due_q.push_back(drive);
    endfunction

    function void check_sda(bit got);
      bit want;
      if (sda_due_q.size() == 0) begin
        $display("%0t: sda_out item with none due: expected none, actual %0b", $time, got);
        errors++;
        return;
      end
      want = sda_due_q.pop_front();
      if (got !== want) begin
        $display("%0t: sda_out mismatch: expected %0b, actual %0b", $time, want, got);
        errors++;
      end
    endfunction

    function void drain_report();
      if (sda_due_q.size() != 0) begin
        $display("%0t: %0d sda_out items never arrived", $time, sda_due_q.size());
        errors++;
      end
    endfunction
  endclass

  sda_line_board board;

  // Pin samples waiting to go out, {sda, scl} per item.
  logic [1:0] pin_q [$];
  int         idle_cycles = 0;
  logic [9:0] stall_tick;

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Bus-level stimulus builders. Each I2C bit is a low sample then a high sample
  // of SCL; SDA changes only while SCL is low, except in start, stop and pin noise.
  // A sample is now and then repeated to stretch a clock phase.
  // ---------------------------------------------------------------------------
  function automatic void pin(bit scl, bit sda);
    pin_q.push_back({sda, scl});
    if ($urandom_range(0, 7) == 0) pin_q.push_back({sda, scl});
  endfunction

  function automatic void bus_start();
    pin(1'b0, 1'b1);
    pin(1'b1, 1'b1);
    pin(1'b1, 1'b0);
  endfunction

  function automatic void bus_stop();
    pin(1'b0, 1'b0);
    pin(1'b1, 1'b0);
    pin(1'b1, 1'b1);
  endfunction

  function automatic void send_bit(bit b);
    pin(1'b0, b);
    pin(1'b1, b);
  endfunction

  // eight bits MSB first plus the ninth (acknowledge) clock at ack_level
  function automatic void send_byte(bit [7:0] v, bit ack_level);
    for (int i = 7; i >= 0; i--) send_bit(v[i]);
    send_bit(ack_level);
  endfunction

  function automatic void noise_pins(int n);
    repeat (n) pin_q.push_back(2'($urandom_range(0, 3)));
  endfunction

  // address byte, pointer byte, n data bytes; the slave's ACK slot level is random
  function automatic void write_txn(bit [6:0] a, bit [7:0] p, int n, bit do_stop);
    bus_start();
    send_byte({a, 1'b0}, 1'($urandom_range(0, 1)));
    send_byte(p, 1'($urandom_range(0, 1)));
    repeat (n) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    if (do_stop) bus_stop();
  endfunction

  // master mostly releases SDA during data bits, ACKs each byte, last one per nack_last
  function automatic void read_txn(bit [6:0] a, int n, bit nack_last, bit do_stop);
    bus_start();
    send_byte({a, 1'b1}, 1'($urandom_range(0, 1)));
    for (int k = 0; k < n; k++) begin
      repeat (8) send_bit($urandom_range(0, 7) != 0);
      send_bit((k == n - 1) ? nack_last : 1'b0);
    end
    if (do_stop) bus_stop();
  endfunction

  // start, one to twenty bits (the first seven are the address), then maybe a stop
  function automatic void broken_txn(bit [6:0] a);
    int nb;
    nb = $urandom_range(1, 20);
    bus_start();
    for (int i = 0; i < nb; i++) begin
      send_bit((i < 7) ? a[6 - i] : 1'($urandom_range(0, 1)));
    end
    if ($urandom_range(0, 1)) bus_stop();
  endfunction

  // mostly small pointers so reads find earlier writes; some near the wrap
  function automatic bit [7:0] pick_ptr();
    case ($urandom_range(0, 9))
      0, 1: return 8'($urandom_range(250, 255));
      2:    return 8'($urandom_range(0, 255));
      default: return 8'($urandom_range(0, 15));
    endcase
  endfunction

  function automatic void directed_traffic();
    bit [6:0] a;
    a = SLAVE_ADDR_RST;
    // all four pin combinations from an idle bus
    pin(1'b1, 1'b1); pin(1'b0, 1'b0); pin(1'b1, 1'b0); pin(1'b0, 1'b1); pin(1'b1, 1'b1);
    // write across the pointer wrap: entries 0xfe, 0xff, 0x00
    write_txn(a, 8'hfe, 3, 1'b1);
    // pointer set, repeated start into a read across the wrap, ending on NACK
    write_txn(a, 8'hfe, 0, 1'b0);
    read_txn(a, 3, 1'b1, 1'b1);
    // read whose last byte is ACKed, stop ends it
    read_txn(a, 1, 1'b0, 1'b1);
    // foreign address: slave must stay released
    write_txn(a ^ 7'h01, 8'h10, 1, 1'b1);
    // start in the middle of an address byte
    bus_start(); send_bit(1'b1); send_bit(1'b0); send_bit(1'b1);
    write_txn(a, 8'h00, 1, 1'b1);
    // stop in the middle of a data byte
    bus_start(); send_byte({a, 1'b0}, 1'b0); send_byte(8'h20, 1'b0);
    send_bit(1'b1); send_bit(1'b0); bus_stop();
    // NACK, then pin noise while the slave waits, then stop
    read_txn(a, 2, 1'b1, 1'b0);
    noise_pins(6);
    bus_stop();
  endfunction

  function automatic void random_traffic(int target, bit [6:0] own);
    int       kind;
    bit [6:0] who;
    while (pin_q.size() < target) begin
      kind = $urandom_range(0, 99);
      who  = ($urandom_range(0, 6) == 0) ? 7'($urandom_range(0, 127)) : own;
      if (kind < 35) begin
        write_txn(who, pick_ptr(), $urandom_range(0, 3), $urandom_range(0, 3) != 0);
      end else if (kind < 60) begin
        read_txn(who, $urandom_range(1, 3), 1'($urandom_range(0, 1)), 1'b1);
      end else if (kind < 80) begin
        write_txn(who, pick_ptr(), 0, 1'b0);
        read_txn(who, $urandom_range(1, 3), 1'($urandom_range(0, 1)), 1'b1);
      end else if (kind < 92) begin
        broken_txn(who);
      end else begin
        noise_pins($urandom_range(2, 10));
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Sends the queued samples in bursts; a burst keeps tvalid high throughout.
  task automatic play_pins();
    int burst;
    int gap;
    while (pin_q.size() != 0) begin
      burst = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 12);
      while (burst != 0 && pin_q.size() != 0) begin
        in_tvalid <= 1'b1;
        in_tdata  <= {6'b0, pin_q[0]};
        @(posedge clk);
        while (!in_tready) @(posedge clk);
        board.take_sample(pin_q[0][0], pin_q[0][1]);
        void'(pin_q.pop_front());
        burst--;
      end
      in_tvalid <= 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(posedge clk);
    end
  endtask

  // Sender stays quiet until every due sda_out item is back, plus the output stage.
  task automatic settle();
    while (board.sda_due_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // APB write of the slave address (upper data bits random, ignored), then read back.
  task automatic set_slave_address(bit [6:0] a);
    logic [31:0] word;
    word      = $urandom();
    word[6:0] = a;
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {REG_SLAVE_ADDR, 2'b00};
    cfg_pwdata  <= word;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    board.set_address(a);
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata[6:0] !== a) begin
      $display("%0t: slave_address readback: expected %0h, actual %0h",
               $time, a, cfg_prdata[6:0]);
      board.errors++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Receiver: stall behavior steps through four modes on stall_tick[8:7] -- always ready,
  // coin flip, mostly stalled, and a regular on/off square.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_tick <= '0;
    end else begin
      stall_tick <= stall_tick + 1'b1;
      case (stall_tick[8:7])
        2'd0:    out_tready <= 1'b1;
        2'd1:    out_tready <= 1'($urandom_range(0, 1));
        2'd2:    out_tready <= ($urandom_range(0, 3) == 0);
        default: out_tready <= stall_tick[2];
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_sda(out_tdata[0]);
  end

  // Hang detector: any handshake or bus access resets the count.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("i2c_slave_byte_ram_core test failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed traffic at the reset address, then random traffic
  // under several slave addresses, extremes included. The address is changed
  // only once the block has returned every due item.
  // ---------------------------------------------------------------------------
  initial begin
    bit [6:0] addr_plan [$];
    board = new();
    addr_plan = '{7'h00, 7'h7f, 7'($urandom_range(1, 126)), SLAVE_ADDR_RST};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_traffic();
    play_pins();
    settle();
    random_traffic(SAMPLES_PER_SETTING, SLAVE_ADDR_RST);
    play_pins();
    settle();

    foreach (addr_plan[i]) begin
      set_slave_address(addr_plan[i]);
      random_traffic(SAMPLES_PER_SETTING, addr_plan[i]);
      play_pins();
      settle();
    end

    board.drain_report();
    if (board.errors == 0) begin
      $display("i2c_slave_byte_ram_core test passed");
    end else begin
      $display("i2c_slave_byte_ram_core test failed");
    end
    $finish;
  end

endmodule

### filelist.f
sv/i2csr_pkg.sv
sv/i2csr_ram.sv
sv/i2c_slave_byte_ram_core.sv
dv/i2c_slave_byte_ram_core_test.sv
